/* design/mkslp_pkg.sv */
// ----------------------------------------------------------------------------
// mkslp_pkg: shared types and constants of the key press detector
// Holds the field widths, event codes, action codes, register indexes and
// reset values, plus the structs passed between the top level and key cells.
// ----------------------------------------------------------------------------
package mkslp_pkg;

    localparam int COUNT_W     = 8;
    localparam int LEVELS_W    = 5;
    localparam int KIND_W      = 2;
    localparam int EVT_KEY_W   = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHORT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

    // input actions
    localparam logic ACT_SCAN  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MINIMUM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_CAP      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVELS  = 2'd3;

    // reset values
    localparam logic [COUNT_W-1:0]  RST_LONG_THRESHOLD = 8'd100;
    localparam logic [COUNT_W-1:0]  RST_SHORT_MINIMUM  = 8'd3;
    localparam logic [COUNT_W-1:0]  RST_COUNT_CAP      = 8'd150;
    localparam logic [LEVELS_W-1:0] RST_ACTIVE_LEVELS  = 5'd1;

    typedef struct packed {
        logic [COUNT_W-1:0]  long_threshold;
        logic [COUNT_W-1:0]  short_minimum;
        logic [COUNT_W-1:0]  count_cap;
        logic [LEVELS_W-1:0] active_levels;
    } cfg_t;

    typedef struct packed {
        logic short_hit;
        logic long_hit;
    } key_evt_t;

endpackage

/* design/mkslp_key_cell.sv */
// ----------------------------------------------------------------------------
// mkslp_key_cell: press counter of one key
// Counts held ticks up to the cap, flags a long press when the count steps
// onto the threshold and a short press on a release inside the short window.
// ----------------------------------------------------------------------------
module mkslp_key_cell
    import mkslp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     tick,
    input  logic     pressed,
    input  cfg_t     cfg,
    output key_evt_t evt
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;

    assign count_inc = count_reg + 8'd1;

    always_comb begin
        count_next    = count_reg;
        evt.short_hit = 1'b0;
        evt.long_hit  = 1'b0;
        if (tick) begin
            if (pressed) begin
                // step only below the cap, hold otherwise
                if (count_reg < cfg.count_cap) begin
                    count_next   = count_inc;
                    evt.long_hit = (count_inc == cfg.long_threshold);
                end
            end else begin
                evt.short_hit = (count_reg >= cfg.short_minimum) &&
                                (count_reg < cfg.long_threshold);
                count_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

/* design/multi_key_short_long_press.sv */
// ----------------------------------------------------------------------------
// multi_key_short_long_press: short and long press detector for push keys
// Scan ticks update one press counter per key and latch the newest event;
// fetch words return the pending event and clear it.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction | word
//  --------+-----------------------------------------+-----------+-------------------------
//  input   | s_valid s_ready s_action s_key_levels   | in        | scan tick or fetch
//  result  | m_valid m_ready m_event_kind m_event_key| out       | one per fetch
//  config  | cfg_valid cfg_ready cfg_index cfg_data  | in        | register write
//
//  Cycles: one word per cycle sustained while no fetch is held. A word is
//  registered in the input register; from there a scan updates the counters
//  and a fetch loads the result register, whose valid flag then rises.
//  Reset (aresetn low, synchronous) clears counters, pending event and valid
//  flags and restores register defaults. A stalled result register holds a
//  waiting fetch in the input register; scans do not wait on it, but queue behind a held fetch.
//
module multi_key_short_long_press
    import mkslp_pkg::*;
#(
    parameter int NUM_KEYS = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [LEVELS_W-1:0]   s_key_levels,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [KIND_W-1:0]     m_event_kind,
    output logic [EVT_KEY_W-1:0]  m_event_key,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers, always ready
    // ------------------------------------------------------------------
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_threshold <= RST_LONG_THRESHOLD;
            cfg_reg.short_minimum  <= RST_SHORT_MINIMUM;
            cfg_reg.count_cap      <= RST_COUNT_CAP;
            cfg_reg.active_levels  <= RST_ACTIVE_LEVELS;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LONG_THRESHOLD: cfg_reg.long_threshold <= cfg_data;
                REG_SHORT_MINIMUM:  cfg_reg.short_minimum  <= cfg_data;
                REG_COUNT_CAP:      cfg_reg.count_cap      <= cfg_data;
                REG_ACTIVE_LEVELS:  cfg_reg.active_levels  <= cfg_data[LEVELS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic                in_vld_reg;
    logic                in_action_reg;
    logic [LEVELS_W-1:0] in_levels_reg;
    logic                out_free;
    logic                proc_go;
    logic                scan_go;
    logic                fetch_go;

    // result register is free when empty or being drained this cycle
    assign out_free = !m_valid || m_ready;
    // scans never wait; a fetch waits for room in the result register
    assign proc_go  = in_vld_reg && ((in_action_reg == ACT_SCAN) || out_free);
    assign scan_go  = proc_go && (in_action_reg == ACT_SCAN);
    assign fetch_go = proc_go && (in_action_reg == ACT_FETCH);
    assign s_ready  = !in_vld_reg || proc_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_levels_reg <= s_key_levels;
        end
    end

    // ------------------------------------------------------------------
    // per-key counters
    // ------------------------------------------------------------------
    key_evt_t key_evt [NUM_KEYS];

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        logic lvl;
        logic act;
        // keys past the level field read low level and low active bit
        if (k < LEVELS_W) begin : g_wired
            assign lvl = in_levels_reg[k];
            assign act = cfg_reg.active_levels[k];
        end else begin : g_unwired
            assign lvl = 1'b0;
            assign act = 1'b0;
        end

        mkslp_key_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tick    (scan_go),
            .pressed (lvl == act),
            .cfg     (cfg_reg),
            .evt     (key_evt[k])
        );
    end

    // ------------------------------------------------------------------
    // pending event: highest-numbered key with an event wins the tick
    // ------------------------------------------------------------------
    logic [KIND_W-1:0]    pend_kind_reg;
    logic [KIND_W-1:0]    pend_kind_next;
    logic [EVT_KEY_W-1:0] pend_key_reg;
    logic [EVT_KEY_W-1:0] pend_key_next;

    always_comb begin
        pend_kind_next = pend_kind_reg;
        pend_key_next  = pend_key_reg;
        if (fetch_go) begin
            pend_kind_next = KIND_NONE;
            pend_key_next  = '0;
        end else if (scan_go) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (key_evt[k].long_hit) begin
                    pend_kind_next = KIND_LONG;
                    pend_key_next  = EVT_KEY_W'(k);
                end else if (key_evt[k].short_hit) begin
                    pend_kind_next = KIND_SHORT;
                    pend_key_next  = EVT_KEY_W'(k);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_kind_reg <= KIND_NONE;
            pend_key_reg  <= '0;
        end else begin
            pend_kind_reg <= pend_kind_next;
            pend_key_reg  <= pend_key_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic                 m_valid_reg;
    logic [KIND_W-1:0]    m_kind_reg;
    logic [EVT_KEY_W-1:0] m_key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= fetch_go;
        end
    end

    // load the pending event; no event reports key zero
    always_ff @(posedge aclk) begin
        if (fetch_go) begin
            m_kind_reg <= pend_kind_reg;
            m_key_reg  <= (pend_kind_reg == KIND_NONE) ? '0 : pend_key_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = m_kind_reg;
    assign m_event_key  = m_key_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_pend_key_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_kind_reg == KIND_NONE) |-> (pend_key_reg == '0))
        else $error("pending key set without a pending event");

    a_fetch_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fetch_go |=> (pend_kind_reg == KIND_NONE))
        else $error("pending event survived a fetch");

    a_fetch_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && (in_action_reg == ACT_FETCH) && m_valid && !m_ready)
        |-> !s_ready)
        else $error("input taken while a fetch is blocked");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_event_kind != KIND_BAD))
        else $error("illegal event kind on result");

endmodule
